FILE: rtl/core/lcs_pkg.sv
// Shared types, constants, weight tables and activation tables of the LSTM cell step.
`timescale 1ns / 1ps
package lcs_pkg;

  // Number format and table geometry
  localparam int FRAC_BITS   = 12;
  localparam int ACT_DEPTH   = 256;
  localparam int ACT_AW      = $clog2(ACT_DEPTH);
  localparam int UNITS       = 3;
  localparam int GATES       = 12;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [15:0] fix_t;
  typedef logic signed [16:0] wgt_t;
  typedef fix_t act_rom_t [ACT_DEPTH];

  // One input beat as it travels from front to back
  typedef struct packed {
    fix_t x_0;
    fix_t x_1;
    fix_t x_2;
    logic seq_start;
  } lcs_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } lcs_state_t;

  // Weights and biases, 16 fractional bits, index k*GATES + j
  localparam wgt_t WX [UNITS*GATES] = '{
    17'sd19496, 17'sd17760, -17'sd7784, -17'sd4633, 17'sd13819, -17'sd3406,
    17'sd33076, -17'sd22852, -17'sd12125, 17'sd20566, 17'sd10570, -17'sd34475,
    -17'sd16701, -17'sd35621, 17'sd19249, 17'sd10495, -17'sd14745, 17'sd5484,
    17'sd11775, -17'sd6342, 17'sd1812, -17'sd36988, 17'sd35891, -17'sd35976,
    -17'sd7335, 17'sd22692, 17'sd5260, 17'sd1867, -17'sd2759, -17'sd151,
    -17'sd14091, -17'sd16321, 17'sd22556, 17'sd23456, 17'sd24975, -17'sd18250};
  localparam wgt_t WH [UNITS*GATES] = '{
    17'sd33225, -17'sd17583, 17'sd28375, 17'sd19449, -17'sd10926, -17'sd18040,
    17'sd37688, -17'sd25256, -17'sd24459, 17'sd33558, -17'sd733, -17'sd26850,
    -17'sd6303, 17'sd37127, 17'sd448, -17'sd20085, -17'sd4148, 17'sd20532,
    17'sd30330, 17'sd23041, 17'sd24577, -17'sd21210, 17'sd5526, 17'sd20584,
    17'sd16193, -17'sd16009, -17'sd19933, 17'sd11128, -17'sd36376, -17'sd9197,
    -17'sd1772, 17'sd11743, 17'sd22971, -17'sd6228, -17'sd28715, -17'sd8873};
  localparam wgt_t BIAS [GATES] = '{
    17'sd40705, -17'sd19756, -17'sd21213, 17'sd35857, 17'sd8147, 17'sd40038,
    -17'sd22877, -17'sd9328, -17'sd19003, -17'sd19460, -17'sd23033, -17'sd24400};

  // Shift-subtract division, used only while building the tables
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f), f and result in Q30, series of twenty truncated terms
  function automatic logic [63:0] exp_frac(input logic [63:0] f);
    longint     sum;
    logic [63:0] term;
    sum  = longint'(64'd1 << 30);
    term = 64'd1 << 30;
    for (int n = 1; n <= 20; n++) begin
      term = udiv((term * f) >> 30, 64'(n));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // exp(-(ip + fr)) in Q30
  function automatic logic [63:0] exp_q30(input logic [63:0] ip, input logic [63:0] fr);
    logic [63:0] e1;
    logic [63:0] r;
    e1 = exp_frac(64'd1 << 30);
    r  = exp_frac(fr);
    for (longint j = 0; j < longint'(ip); j++) r = (r * e1) >> 30;
    return r;
  endfunction

  function automatic fix_t sat_entry(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return fix_t'(v);
  endfunction

  // Sigmoid or tanh table over [-8,8)
  function automatic act_rom_t build_rom(input logic is_tanh);
    act_rom_t    rom;
    longint      n;
    logic [63:0] mag;
    logic [63:0] mag2;
    logic [63:0] e;
    logic [63:0] e2;
    logic [63:0] sn;
    logic [63:0] s;
    logic [63:0] tm;
    logic [63:0] half;
    longint      tr;
    half = 64'd1 << (29 - FRAC_BITS);
    for (int k = 0; k < ACT_DEPTH; k++) begin
      n    = 16 * longint'(k) - 8 * longint'(ACT_DEPTH);
      mag  = (n < 0) ? 64'(-n) : 64'(n);
      mag2 = mag << 1;
      if (!is_tanh) begin
        e  = exp_q30(mag >> ACT_AW, ((mag & 64'(ACT_DEPTH - 1)) << 30) >> ACT_AW);
        sn = udiv(e << 30, (64'd1 << 30) + e);
        s  = (n < 0) ? sn : (64'd1 << 30) - sn;
        rom[k] = sat_entry(longint'((s + half) >> (30 - FRAC_BITS)));
      end else begin
        e2 = exp_q30(mag2 >> ACT_AW, ((mag2 & 64'(ACT_DEPTH - 1)) << 30) >> ACT_AW);
        tm = udiv(((64'd1 << 30) - e2) << 30, (64'd1 << 30) + e2);
        tr = longint'((tm + half) >> (30 - FRAC_BITS));
        rom[k] = sat_entry((n < 0) ? -tr : tr);
      end
    end
    return rom;
  endfunction

  localparam act_rom_t SIG_ROM  = build_rom(1'b0);
  localparam act_rom_t TANH_ROM = build_rom(1'b1);

  // Table index: offset by +8.0, keep the top bits (never out of range in Q4.12)
  function automatic logic [ACT_AW-1:0] act_idx(input fix_t z);
    logic [15:0] t;
    t = {~z[15], z[14:0]};
    return t[15 -: ACT_AW];
  endfunction

  // Round half up by 16 and saturate a gate sum
  function automatic fix_t rnd_sat_gate(input logic signed [35:0] v);
    logic signed [36:0] t;
    logic signed [20:0] s;
    t = 37'(v) + 37'sd32768;
    s = t[36:16];
    if (s > 21'sd32767) return 16'sh7fff;
    if (s < -21'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

  // Round half up by FRAC_BITS and saturate a product sum
  function automatic fix_t rnd_sat_prod(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [21:0] s;
    t = 34'(v) + 34'sd2048;
    s = t[33:12];
    if (s > 22'sd32767) return 16'sh7fff;
    if (s < -22'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

endpackage

FILE: rtl/core/lstm_cell_step_top.sv
// Top level of the three-unit LSTM cell step.
//
//  channel  ports                          handshake
//  input    in_x_0..2, in_seq_start        in_push / in_full
//  result   out_h_0..2                     out_pop / out_empty
//
// Each step runs the three units in turn through one six-multiplier gate
// unit, between taking the beat in IDLE and posting the result in DONE.
// Synchronous active-low reset clears h, c and the queues.
// The input queue keeps taking beats while the engine works; the engine
// holds its finished step only while the output register is still full.
`timescale 1ns / 1ps
module lstm_cell_step_top #(
  parameter int QUEUE_DEPTH = lcs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  lcs_pkg::fix_t in_x_0,
  input  lcs_pkg::fix_t in_x_1,
  input  lcs_pkg::fix_t in_x_2,
  input  logic          in_seq_start,
  output logic          out_empty,
  input  logic          out_pop,
  output lcs_pkg::fix_t out_h_0,
  output lcs_pkg::fix_t out_h_1,
  output lcs_pkg::fix_t out_h_2
);
  lcs_pkg::lcs_item_t in_item, q_item;
  logic q_vld, q_take;

  assign in_item = '{x_0: in_x_0, x_1: in_x_1, x_2: in_x_2, seq_start: in_seq_start};

  lcs_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item, .q_vld, .q_take, .q_item
  );

  lcs_back u_back (
    .clk, .rst_n, .q_vld, .q_take, .q_item, .out_empty, .out_pop,
    .out_h_0, .out_h_1, .out_h_2
  );
endmodule

FILE: rtl/core/lcs_front.sv
// Front: accepts input beats into a short queue that feeds the compute engine.
`timescale 1ns / 1ps
module lcs_front #(
  parameter int QUEUE_DEPTH = lcs_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  lcs_pkg::lcs_item_t in_item,
  output logic              q_vld,
  input  logic              q_take,
  output lcs_pkg::lcs_item_t q_item
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  lcs_pkg::lcs_item_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr_en, rd_en;

  assign in_full = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign wr_en   = in_push && !in_full;
  assign rd_en   = q_take && q_vld;
  assign q_item  = mem_r[rd_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (wr_en) wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (rd_en) rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (rd_en && !wr_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_r] <= in_item;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("queue fill count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count missed a write");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_r == rd_r)) else $error("empty queue with split pointers");
endmodule

FILE: rtl/core/lcs_back.sv
// Back: gate sums, activations, cell update and the output register.
`timescale 1ns / 1ps
module lcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  output logic               q_take,
  input  lcs_pkg::lcs_item_t q_item,
  output logic               out_empty,
  input  logic               out_pop,
  output lcs_pkg::fix_t      out_h_0,
  output lcs_pkg::fix_t      out_h_1,
  output lcs_pkg::fix_t      out_h_2
);
  localparam int U = lcs_pkg::UNITS;

  lcs_pkg::lcs_state_t state_r, state_nxt;
  logic [3:0] st_r;           // step within one unit, 0..10
  logic [1:0] u_r;            // unit
  logic       done_fire;

  lcs_pkg::fix_t x_r  [U];
  lcs_pkg::fix_t h_r  [U];
  lcs_pkg::fix_t c_r  [U];
  lcs_pkg::fix_t hn_r [U];
  lcs_pkg::fix_t oh_r [U];
  logic          out_vld_r;

  logic signed [32:0] px_r [U];
  logic signed [32:0] ph_r [U];
  lcs_pkg::wgt_t      bias_r;
  lcs_pkg::fix_t      z_r;
  lcs_pkg::fix_t      act_r [4];   // input, forget, candidate, output
  logic signed [31:0] cpf_r, cpi_r, hp_r;
  lcs_pkg::fix_t      cn_r, t_r;

  logic [3:0] gate_j;
  logic [1:0] aq;
  logic signed [35:0] gsum;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcs_pkg::ST_IDLE: if (q_vld) state_nxt = lcs_pkg::ST_RUN;
      lcs_pkg::ST_RUN:  if (st_r == 4'd10 && u_r == 2'd2) state_nxt = lcs_pkg::ST_DONE;
      lcs_pkg::ST_DONE: if (!out_vld_r || out_pop) state_nxt = lcs_pkg::ST_IDLE;
      default:          state_nxt = lcs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_take    = 1'b0;
    done_fire = 1'b0;
    unique case (state_r)
      lcs_pkg::ST_IDLE: q_take = q_vld;
      lcs_pkg::ST_RUN:  ;
      lcs_pkg::ST_DONE: done_fire = !out_vld_r || out_pop;
      default:          ;
    endcase
  end

  // gate j = q*UNITS + u issued at steps 0..3
  assign gate_j = {2'b00, st_r[1:0]} * 4'd3 + {2'b00, u_r};
  assign aq     = 2'(st_r - 4'd2);

  always_comb begin
    gsum = 36'(bias_r) <<< lcs_pkg::FRAC_BITS;
    for (int k = 0; k < U; k++) gsum = gsum + 36'(px_r[k]) + 36'(ph_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lcs_pkg::ST_IDLE;
      st_r      <= '0;
      u_r       <= '0;
      out_vld_r <= 1'b0;
      for (int k = 0; k < U; k++) begin
        h_r[k] <= '0;
        c_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // a finished step refills the output register as it drains
      if (done_fire) out_vld_r <= 1'b1;
      else if (out_pop && out_vld_r) out_vld_r <= 1'b0;
      if (q_take) begin
        st_r <= '0;
        u_r  <= '0;
        if (q_item.seq_start) begin
          for (int k = 0; k < U; k++) begin
            h_r[k] <= '0;
            c_r[k] <= '0;
          end
        end
      end
      if (state_r == lcs_pkg::ST_RUN) begin
        if (st_r == 4'd10) begin
          st_r <= '0;
          u_r  <= (u_r == 2'd2) ? 2'd0 : u_r + 1'b1;
        end else begin
          st_r <= st_r + 1'b1;
        end
        // cell value written back for this unit
        if (st_r == 4'd7) c_r[u_r] <= lcs_pkg::rnd_sat_prod(33'(cpf_r) + 33'(cpi_r));
      end
      if (done_fire) begin
        for (int k = 0; k < U; k++) h_r[k] <= hn_r[k];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_take) begin
      x_r[0] <= q_item.x_0;
      x_r[1] <= q_item.x_1;
      x_r[2] <= q_item.x_2;
    end
    if (state_r == lcs_pkg::ST_RUN) begin
      // six products of one gate
      if (st_r <= 4'd3) begin
        for (int k = 0; k < U; k++) begin
          px_r[k] <= x_r[k] * lcs_pkg::WX[6'(k * lcs_pkg::GATES) + 6'(gate_j)];
          ph_r[k] <= h_r[k] * lcs_pkg::WH[6'(k * lcs_pkg::GATES) + 6'(gate_j)];
        end
        bias_r <= lcs_pkg::BIAS[gate_j];
      end
      if (st_r >= 4'd1 && st_r <= 4'd4) z_r <= lcs_pkg::rnd_sat_gate(gsum);
      if (st_r >= 4'd2 && st_r <= 4'd5) begin
        act_r[aq] <= (aq == 2'd2) ? lcs_pkg::TANH_ROM[lcs_pkg::act_idx(z_r)]
                                  : lcs_pkg::SIG_ROM[lcs_pkg::act_idx(z_r)];
      end
      if (st_r == 4'd6) begin
        cpf_r <= act_r[1] * c_r[u_r];
        cpi_r <= act_r[0] * act_r[2];
      end
      if (st_r == 4'd7) cn_r <= lcs_pkg::rnd_sat_prod(33'(cpf_r) + 33'(cpi_r));
      if (st_r == 4'd8) t_r <= lcs_pkg::TANH_ROM[lcs_pkg::act_idx(cn_r)];
      if (st_r == 4'd9) hp_r <= act_r[3] * t_r;
      if (st_r == 4'd10) hn_r[u_r] <= lcs_pkg::rnd_sat_prod(33'(hp_r));
    end
    if (done_fire) begin
      for (int k = 0; k < U; k++) oh_r[k] <= hn_r[k];
    end
  end

  assign out_empty = !out_vld_r;
  assign out_h_0   = oh_r[0];
  assign out_h_1   = oh_r[1];
  assign out_h_2   = oh_r[2];

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r <= 4'd10 && u_r <= 2'd2) else $error("sequencer counter out of range");
  a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcs_pkg::ST_RUN && state_nxt == lcs_pkg::ST_DONE) |-> (u_r == 2'd2))
    else $error("step finished before the last unit");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> state_r == lcs_pkg::ST_IDLE) else $error("item taken while busy");
  a_done_fills: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> out_vld_r) else $error("finished step did not reach output");
endmodule
